// ----- rtl/plc_pkg.sv -----
// Package for the pump level controller: payload structs, register
// indexes, output codes and the display rounding function.
// No dependencies.
package plc_pkg;

  localparam int VOL_W     = 13;
  localparam int ELAPSED_W = 16;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 20;
  localparam int MS_W      = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_SETPOINT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS_BAND = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DWELL_MS    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_LIMIT_MS   = 4'd3;

  localparam logic [VOL_W-1:0] SETPOINT_RST = 13'd2600;
  localparam logic [VOL_W-1:0] BAND_RST     = 13'd200;
  localparam logic [MS_W-1:0]  DWELL_RST    = 20'd2000;
  localparam logic [MS_W-1:0]  FILL_RST     = 20'd30000;

  localparam logic [1:0] DRIVE_STOP  = 2'd0;
  localparam logic [1:0] DRIVE_FILL  = 2'd1;
  localparam logic [1:0] DRIVE_DRAIN = 2'd2;

  localparam logic [1:0] CODE_STOPPED  = 2'd0;
  localparam logic [1:0] CODE_FILLING  = 2'd1;
  localparam logic [1:0] CODE_DRAINING = 2'd2;
  localparam logic [1:0] CODE_ALARM    = 2'd3;

  typedef enum logic [3:0] {
    MODE_STOPPED  = 4'b0001,
    MODE_FILLING  = 4'b0010,
    MODE_DRAINING = 4'b0100,
    MODE_ALARM    = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [VOL_W-1:0]     volume_ml;
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic                 reset_request;
  } item_t;

  typedef struct packed {
    logic [1:0]       pump_drive;
    logic [1:0]       pump_mode;
    logic             leak_alarm;
    logic [VOL_W-1:0] display_level_ml;
  } result_t;

  typedef struct packed {
    logic [VOL_W-1:0] level_setpoint;
    logic [VOL_W-1:0] hysteresis_band;
    logic [MS_W-1:0]  min_dwell_ms;
    logic [MS_W-1:0]  fill_limit_ms;
  } cfg_t;

  // floor(vol / 200) * 200, zero below 600; vol/200 = (vol>>3)/25 by reciprocal
  function automatic logic [VOL_W-1:0] display_level(input logic [VOL_W-1:0] vol);
    logic [9:0]  v8;
    logic [20:0] prod;
    logic [5:0]  q;
    logic [13:0] disp;
    v8   = vol[12:3];
    prod = 21'(v8) * 21'd1311;
    q    = prod[20:15];
    disp = 14'(q) * 14'd200;
    if (q < 6'd3) begin
      disp = '0;
    end
    return disp[VOL_W-1:0];
  endfunction

endpackage

// ----- rtl/plc_cfg_regs.sv -----
// Configuration register file of the pump level controller.
// Depends on plc_pkg.
module plc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [plc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [plc_pkg::CFG_DAT_W-1:0] cfg_data,
  output plc_pkg::cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_setpoint  <= plc_pkg::SETPOINT_RST;
      cfg.hysteresis_band <= plc_pkg::BAND_RST;
      cfg.min_dwell_ms    <= plc_pkg::DWELL_RST;
      cfg.fill_limit_ms   <= plc_pkg::FILL_RST;
    end else if (cfg_valid) begin
      // drop writes beyond the register list
      unique case (cfg_index)
        plc_pkg::CFG_LEVEL_SETPOINT:  cfg.level_setpoint  <= cfg_data[plc_pkg::VOL_W-1:0];
        plc_pkg::CFG_HYSTERESIS_BAND: cfg.hysteresis_band <= cfg_data[plc_pkg::VOL_W-1:0];
        plc_pkg::CFG_MIN_DWELL_MS:    cfg.min_dwell_ms    <= cfg_data[plc_pkg::MS_W-1:0];
        plc_pkg::CFG_FILL_LIMIT_MS:   cfg.fill_limit_ms   <= cfg_data[plc_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/plc_ctrl_core.sv -----
// Pump mode state machine with saturating dwell and fill timers, plus
// the result word for the item it processes. Depends on plc_pkg.
module plc_ctrl_core #(
  parameter int TIMER_WIDTH = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  plc_pkg::item_t   item,
  input  plc_pkg::cfg_t    cfg,
  output plc_pkg::result_t result
);

  localparam int CW = (TIMER_WIDTH > plc_pkg::MS_W) ? TIMER_WIDTH : plc_pkg::MS_W;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

  plc_pkg::mode_t         mode, mode_next, mode_a;
  logic [TIMER_WIDTH-1:0] dwell_timer, dwell_timer_next, dwell_a;
  logic [TIMER_WIDTH-1:0] fill_timer, fill_timer_next, fill_a;
  logic [TIMER_WIDTH:0]   dwell_sum, fill_sum;
  logic                   can_change, fill_over;
  logic signed [14:0]     vol_s, sp_s, band_s;

  always_comb begin
    dwell_sum = {1'b0, dwell_timer} + (TIMER_WIDTH+1)'(item.elapsed_ms);
    fill_sum  = {1'b0, fill_timer} + (TIMER_WIDTH+1)'(item.elapsed_ms);
    dwell_a   = dwell_sum[TIMER_WIDTH] ? TIMER_MAX : dwell_sum[TIMER_WIDTH-1:0];
    fill_a    = fill_sum[TIMER_WIDTH] ? TIMER_MAX : fill_sum[TIMER_WIDTH-1:0];

    mode_a = mode;
    if (item.reset_request && mode == plc_pkg::MODE_ALARM) begin
      mode_a  = plc_pkg::MODE_STOPPED;
      dwell_a = '0;
    end

    can_change = CW'(dwell_a) > CW'(cfg.min_dwell_ms);
    fill_over  = CW'(fill_a) > CW'(cfg.fill_limit_ms);

    vol_s  = signed'(15'(item.volume_ml));
    sp_s   = signed'(15'(cfg.level_setpoint));
    band_s = signed'(15'(cfg.hysteresis_band));

    mode_next        = mode_a;
    dwell_timer_next = dwell_a;
    fill_timer_next  = fill_a;

    unique case (mode_a)
      plc_pkg::MODE_STOPPED: begin
        if (can_change) begin
          if (vol_s < sp_s - band_s) begin
            mode_next        = plc_pkg::MODE_FILLING;
            dwell_timer_next = '0;
            fill_timer_next  = '0;
          end else if (vol_s > sp_s + band_s) begin
            mode_next        = plc_pkg::MODE_DRAINING;
            dwell_timer_next = '0;
          end
        end
      end
      plc_pkg::MODE_FILLING: begin
        // timeout wins over the normal end of filling, dwell not cleared
        if (fill_over) begin
          mode_next = plc_pkg::MODE_ALARM;
        end else if (can_change && vol_s >= sp_s) begin
          mode_next        = plc_pkg::MODE_STOPPED;
          dwell_timer_next = '0;
        end
      end
      plc_pkg::MODE_DRAINING: begin
        if (can_change && vol_s <= sp_s) begin
          mode_next        = plc_pkg::MODE_STOPPED;
          dwell_timer_next = '0;
        end
      end
      plc_pkg::MODE_ALARM: ;
      default: ;
    endcase

    unique case (mode_next)
      plc_pkg::MODE_FILLING: begin
        result.pump_drive = plc_pkg::DRIVE_FILL;
        result.pump_mode  = plc_pkg::CODE_FILLING;
      end
      plc_pkg::MODE_DRAINING: begin
        result.pump_drive = plc_pkg::DRIVE_DRAIN;
        result.pump_mode  = plc_pkg::CODE_DRAINING;
      end
      plc_pkg::MODE_ALARM: begin
        result.pump_drive = plc_pkg::DRIVE_STOP;
        result.pump_mode  = plc_pkg::CODE_ALARM;
      end
      default: begin
        result.pump_drive = plc_pkg::DRIVE_STOP;
        result.pump_mode  = plc_pkg::CODE_STOPPED;
      end
    endcase
    result.leak_alarm       = (mode_next == plc_pkg::MODE_ALARM);
    result.display_level_ml = plc_pkg::display_level(item.volume_ml);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= plc_pkg::MODE_STOPPED;
      dwell_timer <= '0;
      fill_timer  <= '0;
    end else if (en) begin
      mode        <= mode_next;
      dwell_timer <= dwell_timer_next;
      fill_timer  <= fill_timer_next;
    end
  end

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(mode) && $stable(dwell_timer) && $stable(fill_timer))
    else $error("controller state moved without an item");

  a_timeout: assert property (@(posedge clk) disable iff (rst)
    en && mode == plc_pkg::MODE_FILLING && fill_over |=> mode == plc_pkg::MODE_ALARM)
    else $error("fill timeout did not latch the alarm");

  a_alarm_latch: assert property (@(posedge clk) disable iff (rst)
    en && mode == plc_pkg::MODE_ALARM && !item.reset_request
    |=> mode == plc_pkg::MODE_ALARM)
    else $error("alarm left without a reset request");

  a_fill_clear: assert property (@(posedge clk) disable iff (rst)
    en && mode == plc_pkg::MODE_STOPPED && mode_next == plc_pkg::MODE_FILLING
    |=> fill_timer == '0 && dwell_timer == '0)
    else $error("timers not cleared on entering fill");

endmodule

// ----- rtl/pump_level_controller_top.sv -----
// Top level of the pump level controller: input register, controller
// core and result register. Depends on plc_pkg, plc_cfg_regs, plc_ctrl_core.
//
// Usage:
//   item channel   (item_valid, item_stall, item): one control period per
//     word, accepted at a clock edge with item_valid high and item_stall low.
//   result channel (result_valid, result_stall, result): one result word per
//     item, taken at an edge with result_valid high and result_stall low.
//   cfg channel    (cfg_valid, cfg_ready, cfg_index, cfg_data): register
//     writes, always ready; indexes beyond the register list are dropped.
//     Write only while no item is in flight.
// An accepted item passes through the input register and the core into the
// result register, which raises result_valid when it loads the result word.
// Throughput is one item per cycle while result_stall is low, as the mode
// and timer registers update once per item. While result_stall is high the
// result holds and one more item is taken into the input register; after
// that item_stall rises. Synchronous reset clears the pipeline, sets stopped
// mode, zeroes both timers and loads the register defaults.
module pump_level_controller_top #(
  parameter int TIMER_WIDTH = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  plc_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output plc_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [plc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [plc_pkg::CFG_DAT_W-1:0] cfg_data
);

  plc_pkg::cfg_t    cfg;
  plc_pkg::item_t   item_q;
  plc_pkg::result_t core_result;
  logic             item_q_valid;
  logic             advance;

  assign advance    = item_q_valid && (!result_valid || !result_stall);
  assign item_stall = item_q_valid && !advance;

  plc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  plc_ctrl_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_ctrl_core (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .item   (item_q),
    .cfg    (cfg),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (!item_stall) begin
        item_q_valid <= item_valid;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers: load on acceptance, hold otherwise
  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_q <= item;
    end
    if (advance) begin
      result <= core_result;
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Testbench for pump_level_controller_top: a directed table of control periods, then random
// settings and tank-like volume sequences, with every result word checked against a predictor
// or a value given in the table. Depends on plc_pkg and the RTL under rtl/.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VOL_W     = plc_pkg::VOL_W;
  localparam int ELAPSED_W = plc_pkg::ELAPSED_W;
  localparam int CFG_IDX_W = plc_pkg::CFG_IDX_W;
  localparam int CFG_DAT_W = plc_pkg::CFG_DAT_W;
  localparam int MS_W      = plc_pkg::MS_W;
  localparam int JUNK_W    = CFG_DAT_W - VOL_W;

  typedef plc_pkg::item_t   item_t;
  typedef plc_pkg::result_t result_t;

  localparam int TIMER_W = 20;
  localparam longint TIMER_MAX = (longint'(1) << TIMER_W) - 1;
  localparam int DISP_STEP = 200;
  localparam int DISP_MIN = 600;
  localparam int VOL_TOP = 4800;
  localparam int MS_TOP = 1000000;
  localparam int IDLE_GAP = 4;
  localparam int END_GAP = 10;
  localparam int QUIET_LIMIT = 2000;
  localparam int N_SETTINGS = 10;
  localparam int ITEMS_PER_SETTING = 145;
  localparam int MAX_REPORTS = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED = 4'd15;

  typedef struct {
    item_t   w;
    bit      typed;
    result_t res;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  item_t                item = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // predictor copy of the registers and the controller state
  logic [VOL_W-1:0] setpoint_r;
  logic [VOL_W-1:0] band_r;
  logic [MS_W-1:0]  dwell_min_r;
  logic [MS_W-1:0]  fill_limit_r;
  logic [1:0]       ctl_mode;
  longint           dwell_ms;
  longint           fill_ms;

  result_t  expected_outputs[$];
  dir_row_t dir_rows[$];
  int       mismatches = 0;
  int       snd_pct = 0;
  int       rcv_pct = 0;
  int       tank_ml = 0;
  int       quiet_cycles = 0;

  pump_level_controller_top #(.TIMER_WIDTH(TIMER_W)) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial forever #5 clk = ~clk;

  function automatic longint sat_add(longint t, longint d);
    longint s;
    s = t + d;
    return (s > TIMER_MAX) ? TIMER_MAX : s;
  endfunction

  function automatic void reset_controller_model();
    setpoint_r   = plc_pkg::SETPOINT_RST;
    band_r       = plc_pkg::BAND_RST;
    dwell_min_r  = plc_pkg::DWELL_RST;
    fill_limit_r = plc_pkg::FILL_RST;
    ctl_mode     = plc_pkg::CODE_STOPPED;
    dwell_ms     = 0;
    fill_ms      = 0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    case (idx)
      plc_pkg::CFG_LEVEL_SETPOINT:  setpoint_r   = data[VOL_W-1:0];
      plc_pkg::CFG_HYSTERESIS_BAND: band_r       = data[VOL_W-1:0];
      plc_pkg::CFG_MIN_DWELL_MS:    dwell_min_r  = data[MS_W-1:0];
      plc_pkg::CFG_FILL_LIMIT_MS:   fill_limit_r = data[MS_W-1:0];
      default: ;
    endcase
  endfunction

  // advance the controller by one control period and return its output word
  function automatic result_t predict_period(item_t w);
    int      vol;
    int      sp;
    int      band;
    int      disp;
    bit      may_change;
    result_t r;
    vol  = int'(w.volume_ml);
    sp   = int'(setpoint_r);
    band = int'(band_r);
    dwell_ms = sat_add(dwell_ms, longint'(w.elapsed_ms));
    fill_ms  = sat_add(fill_ms, longint'(w.elapsed_ms));
    if (w.reset_request && ctl_mode == plc_pkg::CODE_ALARM) begin
      ctl_mode = plc_pkg::CODE_STOPPED;
      dwell_ms = 0;
    end
    may_change = dwell_ms > longint'(dwell_min_r);
    case (ctl_mode)
      plc_pkg::CODE_STOPPED: begin
        if (may_change) begin
          if (vol < sp - band) begin
            ctl_mode = plc_pkg::CODE_FILLING;
            dwell_ms = 0;
            fill_ms  = 0;
          end else if (vol > sp + band) begin
            ctl_mode = plc_pkg::CODE_DRAINING;
            dwell_ms = 0;
          end
        end
      end
      plc_pkg::CODE_FILLING: begin
        // timeout wins over reaching the setpoint and ignores the dwell
        if (fill_ms > longint'(fill_limit_r)) begin
          ctl_mode = plc_pkg::CODE_ALARM;
        end else if (may_change && vol >= sp) begin
          ctl_mode = plc_pkg::CODE_STOPPED;
          dwell_ms = 0;
        end
      end
      plc_pkg::CODE_DRAINING: begin
        if (may_change && vol <= sp) begin
          ctl_mode = plc_pkg::CODE_STOPPED;
          dwell_ms = 0;
        end
      end
      default: ;
    endcase
    r.pump_drive = (ctl_mode == plc_pkg::CODE_FILLING)  ? plc_pkg::DRIVE_FILL :
                   (ctl_mode == plc_pkg::CODE_DRAINING) ? plc_pkg::DRIVE_DRAIN :
                   plc_pkg::DRIVE_STOP;
    r.pump_mode  = ctl_mode;
    r.leak_alarm = (ctl_mode == plc_pkg::CODE_ALARM);
    disp = (vol / DISP_STEP) * DISP_STEP;
    if (disp < DISP_MIN) begin
      disp = 0;
    end
    r.display_level_ml = disp[VOL_W-1:0];
    return r;
  endfunction

  function automatic item_t make_item(int vol, int el, bit rr);
    item_t w;
    w.volume_ml     = vol[VOL_W-1:0];
    w.elapsed_ms    = el[ELAPSED_W-1:0];
    w.reset_request = rr;
    return w;
  endfunction

  function automatic void row(int vol, int el, bit rr);
    dir_row_t d;
    d.w     = make_item(vol, el, rr);
    d.typed = 1'b0;
    d.res   = '0;
    dir_rows.push_back(d);
  endfunction

  function automatic void row_exp(int vol, int el, bit rr, logic [1:0] drive,
                                  logic [1:0] mode, bit alarm, int disp);
    dir_row_t d;
    d.w     = make_item(vol, el, rr);
    d.typed = 1'b1;
    d.res.pump_drive       = drive;
    d.res.pump_mode        = mode;
    d.res.leak_alarm       = alarm;
    d.res.display_level_ml = disp[VOL_W-1:0];
    dir_rows.push_back(d);
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // mostly a tank that follows the pump, plus values near the thresholds and noise
  function automatic item_t rand_period();
    int vol;
    int el;
    int pick;
    int centre;
    pick = int'($urandom_range(99));
    case (ctl_mode)
      plc_pkg::CODE_FILLING:  tank_ml = tank_ml + int'($urandom_range(150));
      plc_pkg::CODE_DRAINING: tank_ml = tank_ml - int'($urandom_range(150));
      default:                tank_ml = tank_ml + int'($urandom_range(100)) - 50;
    endcase
    tank_ml = clamp(tank_ml, 0, VOL_TOP);
    if (pick < 70) begin
      vol = tank_ml;
    end else if (pick < 85) begin
      centre = int'(setpoint_r) + (int'($urandom_range(2)) - 1) * int'(band_r);
      vol = clamp(centre + int'($urandom_range(8)) - 4, 0, (1 << VOL_W) - 1);
    end else if (pick < 95) begin
      vol = int'($urandom_range(VOL_TOP));
    end else begin
      vol = int'($urandom_range((1 << VOL_W) - 1));
    end
    pick = int'($urandom_range(99));
    if (pick < 40) begin
      el = int'($urandom_range(400));
    end else if (pick < 60) begin
      el = int'($urandom_range(3000));
    end else if (pick < 72) begin
      el = clamp(int'(dwell_min_r) + int'($urandom_range(1)), 0, (1 << ELAPSED_W) - 1);
    end else if (pick < 82) begin
      el = (1 << ELAPSED_W) - 1;
    end else begin
      el = int'($urandom_range((1 << ELAPSED_W) - 1));
    end
    return make_item(vol, el, $urandom_range(99) < 10);
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
  endfunction

  task automatic check_field(string fname, logic [VOL_W-1:0] exp_v, logic [VOL_W-1:0] act_v);
    if (act_v !== exp_v) begin
      flag_mismatch($sformatf("%s expected %0d got %0d", fname, exp_v, act_v));
    end
  endtask

  // called just after a falling edge; returns just after a falling edge with valid still high
  task automatic send_period(item_t w, bit typed, result_t typed_res);
    result_t r;
    while ($urandom_range(99) < snd_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    r = predict_period(w);
    expected_outputs.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (expected_outputs.size() != 0) @(negedge clk);
    repeat (IDLE_GAP) @(negedge clk);
  endtask

  task automatic program_setting(int k);
    logic [CFG_DAT_W-1:0] sp;
    logic [CFG_DAT_W-1:0] band;
    logic [CFG_DAT_W-1:0] dw;
    logic [CFG_DAT_W-1:0] fl;
    case (k)
      0: begin
        sp = CFG_DAT_W'(VOL_TOP); band = '0; dw = '0; fl = '0;
      end
      1: begin
        sp = '0; band = CFG_DAT_W'(VOL_TOP); dw = CFG_DAT_W'(MS_TOP); fl = CFG_DAT_W'(MS_TOP);
      end
      2: begin
        sp   = CFG_DAT_W'(plc_pkg::SETPOINT_RST);
        band = CFG_DAT_W'(plc_pkg::BAND_RST);
        dw   = CFG_DAT_W'(plc_pkg::DWELL_RST);
        fl   = CFG_DAT_W'(plc_pkg::FILL_RST);
      end
      3: begin
        sp = CFG_DAT_W'(VOL_TOP); band = CFG_DAT_W'(VOL_TOP);
        dw = CFG_DAT_W'($urandom_range(500)); fl = CFG_DAT_W'($urandom_range(5000));
      end
      default: begin
        sp   = CFG_DAT_W'($urandom_range(VOL_TOP));
        band = CFG_DAT_W'(($urandom_range(99) < 75) ? $urandom_range(600) :
                                                      $urandom_range(VOL_TOP));
        // junk above the 13-bit registers must be dropped
        sp[CFG_DAT_W-1:VOL_W]   = JUNK_W'($urandom);
        band[CFG_DAT_W-1:VOL_W] = JUNK_W'($urandom);
        case ($urandom_range(2))
          0:       dw = CFG_DAT_W'($urandom_range(5000));
          1:       dw = CFG_DAT_W'($urandom_range(100000));
          default: dw = CFG_DAT_W'($urandom_range(MS_TOP));
        endcase
        case ($urandom_range(2))
          0:       fl = CFG_DAT_W'($urandom_range(60000));
          1:       fl = CFG_DAT_W'($urandom_range(300000));
          default: fl = CFG_DAT_W'($urandom_range(MS_TOP));
        endcase
      end
    endcase
    write_reg(plc_pkg::CFG_LEVEL_SETPOINT, sp);
    write_reg(plc_pkg::CFG_HYSTERESIS_BAND, band);
    write_reg(plc_pkg::CFG_MIN_DWELL_MS, dw);
    write_reg(plc_pkg::CFG_FILL_LIMIT_MS, fl);
    // an index past the list must not touch any register
    write_reg(CFG_IDX_W'($urandom_range(CFG_LAST_UNUSED, CFG_FIRST_UNUSED)),
              CFG_DAT_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < rcv_pct);
  end

  always @(posedge clk) begin
    result_t e;
    if (!rst && result_valid && !result_stall) begin
      if (expected_outputs.size() == 0) begin
        flag_mismatch("result word with nothing pending");
      end else begin
        e = expected_outputs.pop_front();
        check_field("pump_drive", VOL_W'(e.pump_drive), VOL_W'(result.pump_drive));
        check_field("pump_mode", VOL_W'(e.pump_mode), VOL_W'(result.pump_mode));
        check_field("leak_alarm", VOL_W'(e.leak_alarm), VOL_W'(result.leak_alarm));
        check_field("display_level_ml", e.display_level_ml, result.display_level_ml);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    reset_controller_model();
    // register defaults: setpoint 2600, band 200, dwell 2000, fill limit 30000
    row_exp(0, 0, 1'b0, plc_pkg::DRIVE_STOP, plc_pkg::CODE_STOPPED, 1'b0, 0);
    // reset request outside alarm is ignored
    row_exp(VOL_TOP, 0, 1'b1, plc_pkg::DRIVE_STOP, plc_pkg::CODE_STOPPED, 1'b0, VOL_TOP);
    row_exp((1 << VOL_W) - 1, 0, 1'b0, plc_pkg::DRIVE_STOP, plc_pkg::CODE_STOPPED, 1'b0,
            8000);
    row_exp(599, 0, 1'b0, plc_pkg::DRIVE_STOP, plc_pkg::CODE_STOPPED, 1'b0, 0);
    row_exp(600, 0, 1'b0, plc_pkg::DRIVE_STOP, plc_pkg::CODE_STOPPED, 1'b0, 600);
    row_exp(799, 1000, 1'b0, plc_pkg::DRIVE_STOP, plc_pkg::CODE_STOPPED, 1'b0, 600);
    // dwell equal to the minimum is not enough
    row_exp(2600, 1000, 1'b0, plc_pkg::DRIVE_STOP, plc_pkg::CODE_STOPPED, 1'b0, 2600);
    row(2399, 1, 1'b0);
    // fill timeout while already at the setpoint
    row_exp(2600, (1 << ELAPSED_W) - 1, 1'b0, plc_pkg::DRIVE_STOP, plc_pkg::CODE_ALARM,
            1'b1, 2600);
    row_exp(1000, (1 << ELAPSED_W) - 1, 1'b0, plc_pkg::DRIVE_STOP, plc_pkg::CODE_ALARM,
            1'b1, 1000);
    row_exp(1000, 0, 1'b1, plc_pkg::DRIVE_STOP, plc_pkg::CODE_STOPPED, 1'b0, 1000);
    row(1000, 2001, 1'b0);
    row(2600, 2001, 1'b0);
    row(2801, 2001, 1'b0);
    row(2700, 2001, 1'b0);
    row(2600, 2001, 1'b0);
    row(2400, 65535, 1'b0);
    row(2399, 1, 1'b1);
    row(2500, 2000, 1'b0);
    row(2600, 1, 1'b0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    snd_pct = 37;
    rcv_pct = 51;
    foreach (dir_rows[i]) begin
      send_period(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);
    end

    for (int k = 0; k < N_SETTINGS; k++) begin
      if (k == 4) begin
        snd_pct = 51;
        rcv_pct = 37;
      end
      if (k == 7) begin
        snd_pct = 0;
        rcv_pct = 0;
      end
      item_valid <= 1'b0;
      wait_drained();
      program_setting(k);
      tank_ml = int'(setpoint_r);
      repeat (ITEMS_PER_SETTING) send_period(rand_period(), 1'b0, '0);
    end

    item_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(negedge clk);
    repeat (END_GAP) @(posedge clk);
    if (mismatches == 0 && expected_outputs.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
